// ===== rtl/simple_moving_average_unit_assert.svh =====
// Assertion macros for the moving average unit.
// Uses the including module's clk and rst_n; no other dependencies.
`ifndef SIMPLE_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define SIMPLE_MOVING_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define SMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sma_pkg.sv =====
// Shared constants and types for the moving average unit.
// No dependencies.
package sma_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int AVG_W       = 24;
  localparam int CFG_W       = 7;

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
  localparam int DQ_W   = SUM_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DQ_W);

  // magnitude limits of the signed result
  localparam longint AVG_POS_MAX = (longint'(1) << (AVG_W - 1)) - 1;
  localparam longint AVG_NEG_MAG = longint'(1) << (AVG_W - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;      // take sample, write ring, read outgoing slot
    logic sum;       // update running sum
    logic prep;      // load divider
    logic step;      // one quotient bit
    logic out_load;  // move result to output register
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dp_sts_t;

endpackage

// ===== rtl/sma_if.sv =====
// Valid/ready channel interfaces for the moving average unit.
// Depends on sma_pkg for field widths.
interface sma_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sma_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sma_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sma_pkg::AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

interface sma_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sma_pkg::CFG_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

// ===== rtl/sma_controller.sv =====
// Sequencer for the moving average unit: accept, sum, divide, hand off.
// Depends on sma_pkg.
module sma_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output sma_pkg::ctl_cmd_t cmd,
  input  sma_pkg::dp_sts_t  sts
);

  sma_pkg::state_t                state_r, state_nxt;
  logic [sma_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sma_pkg::ST_SUM;
        end
      end
      sma_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = sma_pkg::ST_PREP;
      end
      sma_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sma_pkg::ST_DIV;
      end
      sma_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == sma_pkg::CNT_W'(sma_pkg::DQ_W - 1)) begin
          state_nxt = sma_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      sma_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sma_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/sma_datapath.sv =====
// Datapath: sample ring, running sum, restoring divider, output register.
// Depends on sma_pkg.
module sma_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr,
  input  logic [sma_pkg::CFG_W-1:0]              cfg_window_len,
  input  logic signed [sma_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [sma_pkg::AVG_W-1:0]       out_average,
  input  sma_pkg::ctl_cmd_t                      cmd,
  output sma_pkg::dp_sts_t                       sts
);

  localparam int SB = sma_pkg::SAMPLE_BITS;
  localparam int AW = sma_pkg::ADDR_W;
  localparam int LW = sma_pkg::LEN_W;
  localparam int SW = sma_pkg::SUM_W;
  localparam int DW = sma_pkg::DQ_W;
  localparam int OW = sma_pkg::AVG_W;

  logic signed [SB-1:0] ring_mem [sma_pkg::MAX_WINDOW];

  logic [LW-1:0]                len_r, len_nxt;
  logic [AW-1:0]                wp_r;
  logic [sma_pkg::MAX_WINDOW-1:0] vld_r;
  logic signed [SW-1:0]         sum_r;
  logic signed [SB-1:0]         sample_r;
  logic signed [SB-1:0]         old_r;
  logic                         old_vld_r;
  logic                         neg_r;
  logic [LW-1:0]                rem_r;
  logic [DW-1:0]                dq_r;
  logic signed [OW-1:0]         avg_r, avg_nxt;
  logic                         out_valid_r;

  logic [AW-1:0]                old_idx;
  logic signed [SW-1:0]         old_ext, new_ext;
  logic [SW-1:0]                sum_mag;
  logic [LW:0]                  trial, diff;
  logic                         ge;
  logic [DW-1:0]                quo_signed;

  // slot written len steps ago; wraps onto wp when the window is full size
  assign old_idx = wp_r - len_r[AW-1:0];
  assign old_ext = old_vld_r ? {{(SW-SB){old_r[SB-1]}}, old_r} : '0;
  assign new_ext = {{(SW-SB){sample_r[SB-1]}}, sample_r};
  assign sum_mag = sum_r[SW-1] ? (~sum_r + 1'b1) : sum_r;

  // restoring division step
  assign trial = {rem_r, dq_r[DW-1]};
  assign ge    = (trial >= {1'b0, len_r});
  assign diff  = trial - {1'b0, len_r};

  // register write: 0 means 1, large values clamp to the ring depth
  always_comb begin
    if (cfg_window_len == '0) begin
      len_nxt = LW'(1);
    end else if (int'(cfg_window_len) > sma_pkg::MAX_WINDOW) begin
      len_nxt = LW'(sma_pkg::MAX_WINDOW);
    end else begin
      len_nxt = LW'(cfg_window_len);
    end
  end

  // signed quotient with saturation to the output range
  always_comb begin
    quo_signed = neg_r ? (~dq_r + 1'b1) : dq_r;
    if (!neg_r && (dq_r > DW'(sma_pkg::AVG_POS_MAX))) begin
      avg_nxt = {1'b0, {(OW-1){1'b1}}};
    end else if (neg_r && (dq_r > DW'(sma_pkg::AVG_NEG_MAG))) begin
      avg_nxt = {1'b1, {(OW-1){1'b0}}};
    end else begin
      avg_nxt = quo_signed[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring_mem[wp_r] <= in_sample;
      old_r          <= ring_mem[old_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LW'(1);
      wp_r        <= '0;
      vld_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        len_r <= len_nxt;
        wp_r  <= '0;
        vld_r <= '0;
        sum_r <= '0;
      end else begin
        if (cmd.load) begin
          vld_r[wp_r] <= 1'b1;
          wp_r        <= wp_r + 1'b1;
        end
        if (cmd.sum) begin
          sum_r <= sum_r - old_ext + new_ext;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r  <= in_sample;
      old_vld_r <= vld_r[old_idx];
    end
    if (cmd.prep) begin
      neg_r <= sum_r[SW-1];
      rem_r <= '0;
      dq_r  <= {sum_mag, {sma_pkg::FRAC_BITS{1'b0}}};
    end else if (cmd.step) begin
      rem_r <= ge ? diff[LW-1:0] : trial[LW-1:0];
      dq_r  <= {dq_r[DW-2:0], ge};
    end
    if (cmd.out_load) begin
      avg_r <= avg_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_average  = avg_r;

endmodule

// ===== rtl/simple_moving_average_unit.sv =====
// Moving average unit (boxcar filter): top level.
// Depends on sma_pkg, sma_if.sv, sma_controller, sma_datapath and the assert header.
//
// Each sample transfer on in_chan enters a window of the last window_len samples
// (1..64, set over cfg_chan; 0 is taken as 1, larger values as 64) and yields
// exactly one transfer on out_chan: the window sum divided by window_len,
// signed, 8 fraction bits, truncated toward zero. Reset and every window_len
// write empty the window, so the first outputs after either count the missing
// samples as zeros. One sample is in flight at a time: after the transfer the block
// does the ring read, the running-sum update, the divider load, the bit-serial
// restoring divider (one quotient bit per cycle over the 30-bit scaled sum) and
// the output hand-off, which waits for a free output register. The result sits in
// an output register, so the next sample is taken while a result still waits.
// window_len must be written only while no sample is in flight; not enforced here.
`include "simple_moving_average_unit_assert.svh"

module simple_moving_average_unit (
  input  logic      clk,
  input  logic      rst_n,
  sma_in_if.sink    in_chan,
  sma_out_if.source out_chan,
  sma_cfg_if.sink   cfg_chan
);

  sma_pkg::ctl_cmd_t cmd;
  sma_pkg::dp_sts_t  sts;

  // register writes are always taken
  assign cfg_chan.ready = 1'b1;

  sma_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sma_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_chan.valid && cfg_chan.ready),
    .cfg_window_len (cfg_chan.window_len),
    .in_sample      (in_chan.sample),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_average    (out_chan.average),
    .cmd            (cmd),
    .sts            (sts)
  );

  // busy right after a sample transfer
  `SMA_ASSERT_NEXT(a_busy_after_in, in_chan.valid && in_chan.ready, !in_chan.ready, "ready after transfer")
  // a new result never overwrites one still waiting
  `SMA_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_chan.valid || out_chan.ready, "result overwritten")
  // a loaded result is offered next cycle
  `SMA_ASSERT_NEXT(a_load_shows, cmd.out_load, out_chan.valid, "loaded result not offered")

endmodule

// ===== bench/simple_moving_average_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for simple_moving_average_unit: directed and random samples,
// checked against a built-in boxcar predictor. Depends on sma_pkg, sma_if.sv and the RTL.
module simple_moving_average_unit_tb;
  import sma_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [AVG_W-1:0]       avg_t;

  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam int PHASE_ITEMS  = 56;   // least samples per random window setting
  localparam int N_PHASES     = 9;
  localparam int LONG_STALL   = 500;  // cycles the result side holds off once
  localparam int DRAIN_CYCLES = 40;   // final wait before checking for missing averages

  logic clk;
  logic rst_n;

  sma_in_if  in_chan ();
  sma_out_if out_chan ();
  sma_cfg_if cfg_chan ();

  simple_moving_average_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // ---------------------------------------------------------------------------
  // Boxcar predictor: own copy of the sample ring, write pointer, running sum
  // and window length. Updated only from the transfer monitor below.
  // ---------------------------------------------------------------------------
  sample_t           ring_copy [MAX_WINDOW];
  logic [ADDR_W-1:0] ring_wp;
  longint            run_sum;
  int unsigned       win_len;

  avg_t    avg_expect [$];      // averages still owed by the block
  sample_t sample_backlog [$];  // samples waiting for the input driver
  avg_t    avg_want;

  int samples_queued;
  int samples_taken;
  int mismatch_cnt;
  logic in_taken;               // input transfer happened at the last rising edge

  int send_idle_pct;
  int recv_idle_pct;
  int stall_req;                // bumped by the stimulus to ask for one long stall
  int stall_done;
  int stall_left;

  function automatic void clear_window();
    foreach (ring_copy[i]) ring_copy[i] = '0;
    ring_wp = '0;
    run_sum = 0;
  endfunction

  // a zero length counts as one, anything past the ring size as the ring size;
  // every write restarts warm-up
  function automatic void set_window_len(logic [CFG_W-1:0] code);
    if (code == 0) win_len = 1;
    else if (code > MAX_WINDOW) win_len = MAX_WINDOW;
    else win_len = code;
    clear_window();
  endfunction

  function automatic avg_t boxcar_average(sample_t s);
    logic [ADDR_W-1:0] drop_idx;
    longint            scaled;
    // slot written win_len samples ago; wraps onto ring_wp at the full length
    drop_idx = ring_wp - ADDR_W'(win_len);
    run_sum = run_sum - ring_copy[drop_idx] + s;
    ring_copy[ring_wp] = s;
    ring_wp = ring_wp + 1'b1;
    // signed division truncates toward zero
    scaled = (run_sum * (longint'(1) << FRAC_BITS)) / longint'(win_len);
    if (scaled > AVG_POS_MAX) scaled = AVG_POS_MAX;
    if (scaled < -AVG_NEG_MAG) scaled = -AVG_NEG_MAG;
    return avg_t'(scaled);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #600000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Transfer monitor: sampled at the rising edge, before the block's registers
  // move. Feeds the predictor and checks every result transfer in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      win_len = 1;
      clear_window();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_chan.valid && in_chan.ready;
      if (cfg_chan.valid && cfg_chan.ready) set_window_len(cfg_chan.window_len);
      if (in_chan.valid && in_chan.ready) begin
        avg_expect.push_back(boxcar_average(in_chan.sample));
        samples_taken++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (avg_expect.size() == 0) begin
          $display("%0t: average with none expected: expected nothing, got %0d",
                   $time, out_chan.average);
          mismatch_cnt++;
        end else begin
          avg_want = avg_expect.pop_front();
          if (out_chan.average !== avg_want) begin
            $display("%0t: average mismatch: expected %0d, got %0d",
                     $time, avg_want, out_chan.average);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample driver: changes at the falling edge. A held sample stays until its
  // transfer; after that a new one goes out unless the sender idles.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (sample_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_chan.valid  <= 1'b1;
        in_chan.sample <= sample_backlog.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Result side: random ready, plus one long hold-off on request so the block
  // fills its output register and stalls the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (stall_req != stall_done) begin
      out_chan.ready <= 1'b0;
      stall_left     <= LONG_STALL;
      stall_done     <= stall_done + 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(input sample_t s);
    sample_backlog.push_back(s);
    samples_queued++;
  endtask

  // every sample yields a result, so once all are in and out the block is idle
  task automatic wait_drained();
    while (samples_taken != samples_queued || avg_expect.size() != 0) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [CFG_W-1:0] code);
    @(negedge clk);
    cfg_chan.valid      <= 1'b1;
    cfg_chan.window_len <= code;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic feed_and_drain(input sample_t batch[$]);
    foreach (batch[i]) push_sample(batch[i]);
    wait_drained();
  endtask

  // Mostly random samples and corner values, with occasional runs of a rail
  // value long enough to fill the whole window (peak sums of either sign).
  task automatic random_phase(input logic [CFG_W-1:0] code);
    int      pushed;
    int      pick;
    int      run;
    sample_t s;
    write_window_len(code);
    pushed = 0;
    while (pushed < PHASE_ITEMS) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        s = $urandom_range(1) ? SMP_MAX : SMP_MIN;
        run = win_len + $urandom_range(3);
        repeat (run) push_sample(s);
        pushed += run;
      end else if (pick < 4) begin
        case ($urandom_range(3))
          0:       s = SMP_MAX;
          1:       s = SMP_MIN;
          2:       s = '0;
          default: s = '1;
        endcase
        push_sample(s);
        pushed++;
      end else begin
        s = sample_t'($urandom);
        push_sample(s);
        pushed++;
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] phase_len [N_PHASES];

    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.sample      = '0;
    out_chan.ready      = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.window_len = '0;
    samples_queued      = 0;
    samples_taken       = 0;
    mismatch_cnt        = 0;
    stall_req           = 0;
    stall_done          = 0;
    stall_left          = 0;
    send_idle_pct       = 35;
    recv_idle_pct       = 79;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset length of one: rails, zero, plus and minus one, alternating bit patterns
    feed_and_drain('{SMP_MAX, SMP_MIN, 16'sh0000, -16'sd1, 16'sd1,
                     16'sh5555, 16'shAAAA});
    // zero length is taken as one
    write_window_len(7'd0);
    feed_and_drain('{16'sd100, -16'sd100});
    // length three: negative means truncate toward zero, warm-up zeros count
    write_window_len(7'd3);
    feed_and_drain('{-16'sd1, -16'sd1, 16'sd2, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MAX});
    // all ones saturates to the full ring; the rewrite also empties the window
    write_window_len(7'h7F);
    feed_and_drain('{SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN});
    // just past the ring size
    write_window_len(7'(MAX_WINDOW + 1));
    feed_and_drain('{SMP_MIN});

    phase_len = '{7'(MAX_WINDOW), 7'd1, 7'd5, 7'd0, 7'h7F, 7'd2, 7'd0, 7'd0,
                  7'(MAX_WINDOW)};
    phase_len[6] = 7'($urandom_range(127, 1));
    phase_len[7] = 7'($urandom_range(127));

    // three idle profiles, three window settings each
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 35;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req++;
      end
      random_phase(phase_len[p]);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (avg_expect.size() != 0) begin
      $display("%0t: %0d averages never arrived", $time, avg_expect.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
